// ===== rtl/slcd_pkg.sv =====
// Package for the sync/length/checksum deframer.
// Holds phase and event codes, register indexes and the result record.
// No dependencies.
package slcd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned S_USER_W   = 1;
    localparam int unsigned M_DATA_W   = 32;
    localparam int unsigned M_USER_W   = 2;

    localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hA5;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [TICK_W-1:0] IDLE_MAX      = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_SUM  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_DATA    = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BADSUM  = 2'd2,
        EV_TIMEOUT = 2'd3
    } event_t;

    typedef struct packed {
        logic              valid;
        event_t            kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] pbyte;
        logic [BYTE_W-1:0] pindex;
    } result_t;

endpackage

// ===== rtl/sync_length_checksum_deframer.sv =====
// Top level of the sync/length/checksum deframer: config registers and output register.
// Output: a result is registered and appears on m_ in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; s_tready drops only while a held result is stalled.
// Reset (aresetn low, synchronous): parser returns to sync hunt, counters clear,
// sync_byte = 0xA5, timeout_ticks = 100, output register empties.
module sync_length_checksum_deframer import slcd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,    // [7:0] rx_byte
    input  logic [S_USER_W-1:0]   s_tuser,    // [0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,    // [7:0] frame_command, [15:8] frame_length,
                                              // [23:16] payload_byte, [31:24] payload_index
    output logic [M_USER_W-1:0]   m_tuser,    // [1:0] event_kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [BYTE_W-1:0]   sync_reg;
    logic [TICK_W-1:0]   timeout_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_USER_W-1:0] out_user_reg;
    logic                accept;
    result_t             res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= SYNC_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SYNC_BYTE:     sync_reg    <= cfg_data[BYTE_W-1:0];
                REG_TIMEOUT_TICKS: timeout_reg <= cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    slcd_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .action        (s_tuser[0]),
        .rx_byte       (s_tdata[BYTE_W-1:0]),
        .sync_byte     (sync_reg),
        .timeout_ticks (timeout_reg),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && res.valid) begin
            out_data_reg <= {res.pindex, res.pbyte, res.length, res.command};
            out_user_reg <= res.kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/slcd_core.sv =====
// Frame parser state machine: tracks phase, checksum, byte count and idle ticks.
// Produces at most one result per accepted transaction, combinationally.
// Depends on slcd_pkg.
module slcd_core import slcd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              action,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] sync_byte,
    input  logic [TICK_W-1:0] timeout_ticks,
    output result_t           res
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] taken_reg, taken_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [TICK_W-1:0] idle_reg, idle_next;

    logic [TICK_W-1:0] idle_inc;
    logic              timed_out;
    logic [BYTE_W-1:0] taken_inc;

    assign idle_inc  = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
    assign timed_out = (phase_reg != PH_HUNT) && (idle_inc >= timeout_ticks);
    assign taken_inc = taken_reg + 1'b1;

    // next state
    always_comb begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        taken_next   = taken_reg;
        sum_next     = sum_reg;
        idle_next    = idle_reg;
        if (accept) begin
            if (action == ACT_TICK) begin
                if (phase_reg != PH_HUNT) begin
                    if (timed_out) begin
                        phase_next = PH_HUNT;
                        idle_next  = '0;
                    end else begin
                        idle_next = idle_inc;
                    end
                end
            end else begin
                idle_next = '0;
                case (phase_reg)
                    PH_CMD: begin
                        command_next = rx_byte;
                        sum_next     = rx_byte;
                        phase_next   = PH_LEN;
                    end
                    PH_LEN: begin
                        length_next = rx_byte;
                        sum_next    = sum_reg + rx_byte;
                        taken_next  = '0;
                        phase_next  = (rx_byte == '0) ? PH_SUM : PH_DATA;
                    end
                    PH_DATA: begin
                        sum_next   = sum_reg + rx_byte;
                        taken_next = taken_inc;
                        if (taken_inc == length_reg) begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        phase_next = PH_HUNT;
                    end
                    default: begin
                        phase_next = PH_HUNT;
                        if (rx_byte == sync_byte) begin
                            command_next = '0;
                            length_next  = '0;
                            taken_next   = '0;
                            sum_next     = '0;
                            phase_next   = PH_CMD;
                        end
                    end
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        res.valid   = 1'b0;
        res.kind    = EV_DATA;
        res.command = command_reg;
        res.length  = length_reg;
        res.pbyte   = '0;
        res.pindex  = '0;
        if (accept) begin
            if (action == ACT_TICK) begin
                if (timed_out) begin
                    res.valid = 1'b1;
                    res.kind  = EV_TIMEOUT;
                end
            end else begin
                case (phase_reg)
                    PH_DATA: begin
                        res.valid  = 1'b1;
                        res.kind   = EV_DATA;
                        res.pbyte  = rx_byte;
                        res.pindex = taken_reg;
                    end
                    PH_SUM: begin
                        res.valid = 1'b1;
                        res.kind  = (rx_byte == sum_reg) ? EV_GOOD : EV_BADSUM;
                    end
                    default: begin
                        res.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            command_reg <= '0;
            length_reg  <= '0;
            taken_reg   <= '0;
            sum_reg     <= '0;
            idle_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            taken_reg   <= taken_next;
            sum_reg     <= sum_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

// ===== verif/slcd_frame_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sync/length/checksum deframer: watches the input, config and
// result channels, predicts each result and compares it field by field.
// Depends on slcd_pkg.
module slcd_frame_checker import slcd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,    // [7:0] rx_byte
    input  logic [S_USER_W-1:0]   s_tuser,    // [0] action
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,    // [7:0] frame_command, [15:8] frame_length,
                                              // [23:16] payload_byte, [31:24] payload_index
    input  logic [M_USER_W-1:0]   m_tuser,    // [1:0] event_kind
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           fail_count,
    output int unsigned           pending
);

    typedef struct packed {
        event_t            kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] pbyte;
        logic [BYTE_W-1:0] pindex;
    } frame_event_t;

    frame_event_t      expected_events[$];
    int unsigned       n_fail = 0;
    int unsigned       n_pending = 0;

    logic [BYTE_W-1:0] sync_reg;
    logic [TICK_W-1:0] timeout_reg;
    phase_t            parse_phase;
    logic [BYTE_W-1:0] cur_cmd;
    logic [BYTE_W-1:0] cur_len;
    logic [BYTE_W-1:0] n_taken;
    logic [BYTE_W-1:0] run_sum;
    logic [TICK_W-1:0] idle_ticks;

    assign fail_count = n_fail;
    assign pending    = n_pending;

    function automatic void deframe_step(input logic act, input logic [BYTE_W-1:0] b);
        frame_event_t ev;
        ev = '{kind: EV_DATA, command: cur_cmd, length: cur_len, pbyte: 8'd0, pindex: 8'd0};
        if (act == ACT_TICK) begin
            if (parse_phase == PH_HUNT) return;
            if (idle_ticks != IDLE_MAX) idle_ticks = idle_ticks + 1'b1;
            // a zero limit fires on the first tick as well
            if (idle_ticks >= timeout_reg) begin
                ev.kind = EV_TIMEOUT;
                expected_events.push_back(ev);
                parse_phase = PH_HUNT;
                idle_ticks = '0;
            end
            return;
        end
        idle_ticks = '0;
        case (parse_phase)
            PH_CMD: begin
                cur_cmd = b;
                run_sum = b;
                parse_phase = PH_LEN;
            end
            PH_LEN: begin
                cur_len = b;
                run_sum = run_sum + b;
                n_taken = '0;
                parse_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                ev.pbyte = b;
                ev.pindex = n_taken;
                run_sum = run_sum + b;
                n_taken = n_taken + 1'b1;
                if (n_taken == cur_len) parse_phase = PH_SUM;
                expected_events.push_back(ev);
            end
            PH_SUM: begin
                ev.kind = (b == run_sum) ? EV_GOOD : EV_BADSUM;
                expected_events.push_back(ev);
                parse_phase = PH_HUNT;
            end
            default: begin
                parse_phase = PH_HUNT;
                if (b == sync_reg) begin
                    cur_cmd = '0;
                    cur_len = '0;
                    n_taken = '0;
                    run_sum = '0;
                    parse_phase = PH_CMD;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge aclk) begin
        frame_event_t want;
        if (!aresetn) begin
            sync_reg    = SYNC_RESET;
            timeout_reg = TIMEOUT_RESET;
            parse_phase = PH_HUNT;
            cur_cmd     = '0;
            cur_len     = '0;
            n_taken     = '0;
            run_sum     = '0;
            idle_ticks  = '0;
            expected_events.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $error("event_kind: expected none, got %0d", m_tuser);
                    n_fail++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", {6'd0, want.kind}, {6'd0, m_tuser});
                    check_field("frame_command", want.command, m_tdata[7:0]);
                    check_field("frame_length", want.length, m_tdata[15:8]);
                    check_field("payload_byte", want.pbyte, m_tdata[23:16]);
                    check_field("payload_index", want.pindex, m_tdata[31:24]);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SYNC_BYTE) sync_reg = cfg_data[7:0];
                else if (cfg_index == REG_TIMEOUT_TICKS) timeout_reg = cfg_data;
            end
            if (s_tvalid && s_tready) deframe_step(s_tuser[0], s_tdata[7:0]);
        end
        n_pending = expected_events.size();
    end

endmodule

// ===== verif/sync_length_checksum_deframer_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the sync/length/checksum deframer: clock, reset, stimulus
// and verdict. Directed frames first, then random frames under several register
// settings and idle patterns. Depends on slcd_pkg, sync_length_checksum_deframer and slcd_frame_checker.
module sync_length_checksum_deframer_tb import slcd_pkg::*; ();

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;      // [7:0] rx_byte
    logic [S_USER_W-1:0]   s_tuser = '0;      // [0] action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;           // [7:0] command, [15:8] length,
                                              // [23:16] payload byte, [31:24] index
    logic [M_USER_W-1:0]   m_tuser;           // [1:0] event_kind
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned           n_fail;
    int unsigned           n_pending;
    int                    gap_pct = 0;
    int                    stall_pct = 0;
    int unsigned           sent_items = 0;
    logic [BYTE_W-1:0]     cur_sync = SYNC_RESET;
    logic [TICK_W-1:0]     cur_tmo = TIMEOUT_RESET;

    sync_length_checksum_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slcd_frame_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (n_fail),
        .pending    (n_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // called and returns at a falling edge
    task automatic push_item(input logic act, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_items++;
    endtask

    task automatic tick();
        push_item(ACT_TICK, 8'($urandom_range(255)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // len_sel < 0: random length, may be cut short and left to time out
    task automatic send_frame(input int len_sel);
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] cmd, len, sum, nb;
        int                n_noise, stop, burst;
        bit                truncate;
        n_noise = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n_noise) begin
            if ($urandom_range(1)) begin
                tick();
            end else begin
                do nb = 8'($urandom_range(255)); while (nb == cur_sync);
                push_item(ACT_BYTE, nb);
            end
        end
        cmd = 8'($urandom_range(255));
        if (len_sel >= 0) len = 8'(len_sel);
        else len = 8'(($urandom_range(49) == 0) ? $urandom_range(255) : $urandom_range(8));
        body.push_back(cmd);
        body.push_back(len);
        sum = cmd + len;
        for (int k = 0; k < len; k++) begin
            nb = 8'($urandom_range(255));
            body.push_back(nb);
            sum = sum + nb;
        end
        if ($urandom_range(3) == 0) sum = sum ^ (8'd1 << $urandom_range(7));
        body.push_back(sum);
        truncate = (len_sel < 0) && ($urandom_range(19) == 0) && (cur_tmo <= 300);
        stop = truncate ? $urandom_range(body.size() - 1) : body.size();
        push_item(ACT_BYTE, cur_sync);
        for (int k = 0; k < stop; k++) begin
            if ($urandom_range(9) == 0) begin
                burst = $urandom_range(1, 3);
                if (burst < cur_tmo) repeat (burst) tick();
            end
            push_item(ACT_BYTE, body[k]);
        end
        if (truncate) repeat (cur_tmo) tick();
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] sync, input logic [TICK_W-1:0] tmo,
                             input int gap, input int stall, input bit long_idle,
                             input bit long_frame);
        int unsigned stop_at;
        gap_pct   = gap;
        stall_pct = stall;
        write_reg(REG_SYNC_BYTE, {8'($urandom_range(255)), sync});
        write_reg(REG_TIMEOUT_TICKS, tmo);
        cur_sync = sync;
        cur_tmo  = tmo;
        if (long_idle) begin
            push_item(ACT_BYTE, cur_sync);
            push_item(ACT_BYTE, 8'h5A);
            repeat (cur_tmo) tick();
        end
        if (long_frame) send_frame(255);
        stop_at = sent_items + 110;
        while (sent_items < stop_at) send_frame(-1);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset register values, no idling
        tick();
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_BYTE, 8'hA5);     // zero-length frame, good sum
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_BYTE, 8'hA5);     // sync value as payload, bad sum
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'h02);
        push_item(ACT_BYTE, 8'hA5);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'hA5);     // sum wraps to zero
        push_item(ACT_BYTE, 8'h7E);
        push_item(ACT_BYTE, 8'h01);
        push_item(ACT_BYTE, 8'h81);
        push_item(ACT_BYTE, 8'h00);
        drain();

        // zero timeout: first tick in a frame abandons it
        write_reg(REG_TIMEOUT_TICKS, 16'd0);
        cur_tmo = 16'd0;
        push_item(ACT_BYTE, 8'hA5);
        tick();
        push_item(ACT_BYTE, 8'hA5);
        push_item(ACT_BYTE, 8'h33);
        tick();
        push_item(ACT_BYTE, 8'hA5);
        push_item(ACT_BYTE, 8'h33);
        push_item(ACT_BYTE, 8'h02);
        tick();
        drain();

        run_phase(8'h00, 16'd1, 83, 0, 1'b0, 1'b0);
        run_phase(8'hFF, 16'hFFFF, 0, 83, 1'b0, 1'b0);
        run_phase(8'($urandom_range(255)), 16'($urandom_range(2, 8)), 27, 27, 1'b1, 1'b0);
        run_phase(8'hA5, 16'($urandom_range(1, 200)), 0, 0, 1'b0, 1'b1);
        run_phase(8'($urandom_range(255)), 16'd2, 83, 0, 1'b0, 1'b0);

        if (n_fail == 0) begin
            $display("sync_length_checksum_deframer: match");
        end else begin
            $display("sync_length_checksum_deframer: mismatch");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("sync_length_checksum_deframer: mismatch");
        $finish;
    end

endmodule
